/* hw/rtl/spherical_vector_add_assert.svh */
// ----------------------------------------------------------------------------
// spherical_vector_add_assert.svh
// Assertion macros for the spherical vector adder.
// ----------------------------------------------------------------------------
`ifndef SPHERICAL_VECTOR_ADD_ASSERT_SVH
`define SPHERICAL_VECTOR_ADD_ASSERT_SVH

`ifndef SYNTH
// property must hold on every clock out of reset
`define SVA_CHECK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// condition must never be seen out of reset
`define SVA_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define SVA_CHECK(lbl, clk, rstn, prop)
`define SVA_NEVER(lbl, clk, rstn, cond)
`endif

`endif

/* hw/rtl/svadd_pkg.sv */
// ----------------------------------------------------------------------------
// svadd_pkg
// Shared constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package svadd_pkg;

    localparam int RADIUS_BITS_DEF = 32;
    localparam int ANGLE_BITS_DEF  = 16;

    localparam int STEPS   = 30;   // CORDIC iterations
    localparam int TURN_W  = 32;   // internal binary turn
    localparam int FRAC_W  = 30;   // Q30 unit components
    localparam int FULL_R  = 56;   // radius plus guard bits
    localparam int RAD_W   = FULL_R + 1;
    localparam int ROT_W   = 33;   // unit vector datapath
    localparam int CART_W  = 58;   // one Cartesian component
    localparam int SUM_W   = 59;   // sum of two components
    localparam int VEC_W   = 60;   // vectoring datapath

    localparam logic signed [ROT_W-1:0] INV_GAIN = 33'sd652032874;

    function automatic logic [TURN_W-1:0] atan_turn(input int unsigned idx);
        logic [TURN_W-1:0] v;
        unique case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/svadd_dly.sv */
// ----------------------------------------------------------------------------
// svadd_dly
// Enabled delay line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module svadd_dly #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W-1:0] d,
    output logic      [W-1:0] q
);

    logic [W-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++)
            begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

/* hw/rtl/svadd_mulq.sv */
// ----------------------------------------------------------------------------
// svadd_mulq
// Two-stage signed multiply by a Q30 factor, magnitude truncated.
// ----------------------------------------------------------------------------
`default_nettype none

module svadd_mulq #(
    parameter int VW = 57,
    parameter int OW = 58
) (
    input  wire logic                                  clk,
    input  wire logic                                  en,
    input  wire logic signed [VW-1:0]                  v,
    input  wire logic signed [svadd_pkg::ROT_W-1:0]    c,
    output logic signed      [OW-1:0]                  p
);

    localparam int FW = svadd_pkg::FRAC_W;
    localparam int HW = VW - FW;
    localparam int KW = FW + 1;
    localparam int LW = FW + KW;
    localparam int PW = HW + KW + 1;

    logic [VW-1:0]                 mag;
    logic [svadd_pkg::ROT_W-1:0]   kabs;
    logic [KW-1:0]                 k;
    logic [HW+KW-1:0]              hi_next, hi_reg;
    logic [LW-1:0]                 lo_next, lo_reg;
    logic                          neg_next, neg_reg;
    logic [PW-1:0]                 psum;
    logic signed [PW:0]            pres;
    logic signed [OW-1:0]          p_next, p_reg;

    always_comb
    begin
        mag      = v[VW-1] ? $unsigned(-v) : $unsigned(v);
        kabs     = c[svadd_pkg::ROT_W-1] ? $unsigned(-c) : $unsigned(c);
        k        = kabs[KW-1:0];
        neg_next = v[VW-1] ^ c[svadd_pkg::ROT_W-1];
        hi_next  = mag[VW-1:FW] * k;
        lo_next  = mag[FW-1:0] * k;
    end

    always_comb
    begin
        psum   = {1'b0, hi_reg} + {{(PW-KW){1'b0}}, lo_reg[LW-1:FW]};
        pres   = neg_reg ? -$signed({1'b0, psum}) : $signed({1'b0, psum});
        p_next = pres[OW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_reg  <= hi_next;
            lo_reg  <= lo_next;
            neg_reg <= neg_next;
            p_reg   <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

/* hw/rtl/svadd_rot.sv */
// ----------------------------------------------------------------------------
// svadd_rot
// Pipelined rotation CORDIC: cosine and sine (Q30) of a binary turn.
// ----------------------------------------------------------------------------
`default_nettype none

module svadd_rot (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic [svadd_pkg::TURN_W-1:0]        ang,
    output logic signed [svadd_pkg::ROT_W-1:0]       cos_q,
    output logic signed [svadd_pkg::ROT_W-1:0]       sin_q
);

    localparam int N = svadd_pkg::STEPS;
    localparam int W = svadd_pkg::ROT_W;
    localparam int T = svadd_pkg::TURN_W;

    logic signed [W-1:0] x_reg [0:N];
    logic signed [W-1:0] y_reg [0:N];
    logic signed [W-1:0] z_reg [0:N];
    logic                flip_reg [0:N];
    logic signed [W-1:0] x_next [0:N];
    logic signed [W-1:0] y_next [0:N];
    logic signed [W-1:0] z_next [0:N];
    logic                flip_next [0:N];

    logic [T-1:0] ang_q;
    logic [T-1:0] ang_f;

    // fold into [-pi/2, pi/2], negate result later
    always_comb
    begin
        ang_q        = ang + 32'h4000_0000;
        flip_next[0] = ang_q[T-1];
        ang_f        = flip_next[0] ? ang + 32'h8000_0000 : ang;
        x_next[0]    = svadd_pkg::INV_GAIN;
        y_next[0]    = '0;
        z_next[0]    = $signed({ang_f[T-1], ang_f});
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        logic signed [W-1:0] dx, dy, at;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign at = $signed({1'b0, svadd_pkg::atan_turn(i)});

        always_comb
        begin
            flip_next[i+1] = flip_reg[i];
            if (!z_reg[i][W-1])
            begin
                x_next[i+1] = x_reg[i] - dx;
                y_next[i+1] = y_reg[i] + dy;
                z_next[i+1] = z_reg[i] - at;
            end
            else
            begin
                x_next[i+1] = x_reg[i] + dx;
                y_next[i+1] = y_reg[i] - dy;
                z_next[i+1] = z_reg[i] + at;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= N; k++)
            begin
                x_reg[k]    <= x_next[k];
                y_reg[k]    <= y_next[k];
                z_reg[k]    <= z_next[k];
                flip_reg[k] <= flip_next[k];
            end
        end
    end

    assign cos_q = flip_reg[N] ? -x_reg[N] : x_reg[N];
    assign sin_q = flip_reg[N] ? -y_reg[N] : y_reg[N];

endmodule

`default_nettype wire

/* hw/rtl/svadd_vec.sv */
// ----------------------------------------------------------------------------
// svadd_vec
// Pipelined vectoring CORDIC: gain-scaled length and angle of (x, y).
// ----------------------------------------------------------------------------
`default_nettype none

module svadd_vec (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic signed [svadd_pkg::VEC_W-1:0]  x_in,
    input  wire logic signed [svadd_pkg::VEC_W-1:0]  y_in,
    output logic signed      [svadd_pkg::VEC_W-1:0]  len,
    output logic             [svadd_pkg::TURN_W-1:0] ang
);

    localparam int N = svadd_pkg::STEPS;
    localparam int W = svadd_pkg::VEC_W;
    localparam int T = svadd_pkg::TURN_W;

    logic signed [W-1:0] x_reg [0:N];
    logic signed [W-1:0] y_reg [0:N];
    logic [T-1:0]        z_reg [0:N];
    logic signed [W-1:0] x_next [0:N];
    logic signed [W-1:0] y_next [0:N];
    logic [T-1:0]        z_next [0:N];

    // left half plane: rotate by pi first
    always_comb
    begin
        if (x_in[W-1])
        begin
            x_next[0] = -x_in;
            y_next[0] = -y_in;
            z_next[0] = 32'h8000_0000;
        end
        else
        begin
            x_next[0] = x_in;
            y_next[0] = y_in;
            z_next[0] = '0;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        logic signed [W-1:0] dx, dy;
        logic [T-1:0]        at;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign at = svadd_pkg::atan_turn(i);

        always_comb
        begin
            if (y_reg[i][W-1])
            begin
                x_next[i+1] = x_reg[i] - dx;
                y_next[i+1] = y_reg[i] + dy;
                z_next[i+1] = z_reg[i] - at;
            end
            else
            begin
                x_next[i+1] = x_reg[i] + dx;
                y_next[i+1] = y_reg[i] - dy;
                z_next[i+1] = z_reg[i] + at;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= N; k++)
            begin
                x_reg[k] <= x_next[k];
                y_reg[k] <= y_next[k];
                z_reg[k] <= z_next[k];
            end
        end
    end

    assign len = x_reg[N];
    assign ang = z_reg[N];

endmodule

`default_nettype wire

/* hw/rtl/spherical_vector_add.sv */
// ----------------------------------------------------------------------------
// spherical_vector_add
// Adds two points given in spherical form and returns the sum in spherical
// form, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input request (in_valid/in_ready) carries two points: radius (unsigned
//   fixed point, 16 fraction bits at the default width), polar angle (half
//   turn = 2^(ANGLE_BITS-1)) and azimuth (full turn = 2^ANGLE_BITS).
//   Output request (out_valid/out_ready) carries radius, polar angle and
//   azimuth of the vector sum plus a saturation flag for the radius.
//   Pipeline: input register, 31-stage rotation CORDIC, two 2-stage
//   multiplies, add stage, 31-stage vectoring CORDIC with gain multiply,
//   twice, then the rounding register.
//   Throughput: one request per cycle while results are taken; most stages
//   are one CORDIC step or one half of a Q30 multiply.
//   Stall: a result not taken freezes the pipeline; the input register still
//   takes one more request while it is empty. Nothing is dropped or repeated.
//   Reset: all valid bits clear, pipeline empty, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spherical_vector_add_assert.svh"

module spherical_vector_add #(
    parameter int RADIUS_BITS = svadd_pkg::RADIUS_BITS_DEF,
    parameter int ANGLE_BITS  = svadd_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [RADIUS_BITS-1:0] a_radius,
    input  wire logic [ANGLE_BITS-1:0]  a_polar,
    input  wire logic [ANGLE_BITS-1:0]  a_azimuth,
    input  wire logic [RADIUS_BITS-1:0] b_radius,
    input  wire logic [ANGLE_BITS-1:0]  b_polar,
    input  wire logic [ANGLE_BITS-1:0]  b_azimuth,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [RADIUS_BITS-1:0]      sum_radius,
    output logic [ANGLE_BITS-1:0]       sum_polar,
    output logic [ANGLE_BITS-1:0]       sum_azimuth,
    output logic                        radius_overflow
);

    localparam int N      = svadd_pkg::STEPS;
    localparam int T      = svadd_pkg::TURN_W;
    localparam int RW     = svadd_pkg::ROT_W;
    localparam int CW     = svadd_pkg::CART_W;
    localparam int SW     = svadd_pkg::SUM_W;
    localparam int VW     = svadd_pkg::VEC_W;
    localparam int FR     = svadd_pkg::FULL_R;
    localparam int GUARD  = FR - RADIUS_BITS;
    localparam int ASHIFT = T - ANGLE_BITS;

    // stage numbers (register that holds the value)
    localparam int ST_ROT = N + 1;
    localparam int ST_M1  = ST_ROT + 2;
    localparam int ST_M2  = ST_M1 + 2;
    localparam int ST_SUM = ST_M2 + 1;
    localparam int ST_V1  = ST_SUM + N + 1;
    localparam int ST_G1  = ST_V1 + 2;
    localparam int ST_V2  = ST_G1 + N + 1;
    localparam int ST_G2  = ST_V2 + 2;
    localparam int ST_OUT = ST_G2 + 1;

    localparam logic [T-1:0]            HALF_A  = T'(1) << (ASHIFT - 1);
    localparam logic [VW:0]             HALF_R  = (VW + 1)'(1) << (GUARD - 1);
    localparam logic [ANGLE_BITS-1:0]   PI_CODE = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

    // ---------------- pipeline control ----------------
    logic [ST_OUT:0] vld_reg, vld_next;
    logic            en;     // stages 1..ST_OUT advance
    logic            ld0;    // input register loads

    assign en       = !vld_reg[ST_OUT] || out_ready;
    assign ld0      = en || !vld_reg[0];
    assign in_ready = ld0;
    assign out_valid = vld_reg[ST_OUT];

    always_comb
    begin
        vld_next = vld_reg;
        if (ld0)
        begin
            vld_next[0] = in_valid;
        end
        if (en)
        begin
            vld_next[ST_OUT:1] = vld_reg[ST_OUT-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // ---------------- input register ----------------
    logic [RADIUS_BITS-1:0] a_rad_reg, b_rad_reg;
    logic [ANGLE_BITS-1:0]  a_pol_reg, a_az_reg, b_pol_reg, b_az_reg;

    always_ff @(posedge clk)
    begin
        if (ld0)
        begin
            a_rad_reg <= a_radius;
            a_pol_reg <= a_polar;
            a_az_reg  <= a_azimuth;
            b_rad_reg <= b_radius;
            b_pol_reg <= b_polar;
            b_az_reg  <= b_azimuth;
        end
    end

    // ---------------- unit vectors ----------------
    logic signed [RW-1:0] a_ct, a_st, a_cp, a_sp, b_ct, b_st, b_cp, b_sp;

    svadd_rot u_rot_apol (.clk(clk), .en(en), .ang({a_pol_reg, {ASHIFT{1'b0}}}),
                          .cos_q(a_ct), .sin_q(a_st));
    svadd_rot u_rot_aaz  (.clk(clk), .en(en), .ang({a_az_reg, {ASHIFT{1'b0}}}),
                          .cos_q(a_cp), .sin_q(a_sp));
    svadd_rot u_rot_bpol (.clk(clk), .en(en), .ang({b_pol_reg, {ASHIFT{1'b0}}}),
                          .cos_q(b_ct), .sin_q(b_st));
    svadd_rot u_rot_baz  (.clk(clk), .en(en), .ang({b_az_reg, {ASHIFT{1'b0}}}),
                          .cos_q(b_cp), .sin_q(b_sp));

    // radii wait for the rotations
    logic [2*RADIUS_BITS-1:0] rad_d;
    logic signed [FR:0]       a_r, b_r;

    svadd_dly #(.W(2*RADIUS_BITS), .DEPTH(ST_ROT)) u_dly_rad (
        .clk(clk), .en(en), .d({a_rad_reg, b_rad_reg}), .q(rad_d));

    assign a_r = $signed({1'b0, rad_d[2*RADIUS_BITS-1:RADIUS_BITS], {GUARD{1'b0}}});
    assign b_r = $signed({1'b0, rad_d[RADIUS_BITS-1:0], {GUARD{1'b0}}});

    // ---------------- to Cartesian ----------------
    logic signed [CW-1:0] a_rho, a_z, b_rho, b_z;

    svadd_mulq #(.VW(FR+1), .OW(CW)) u_mul_arho (.clk(clk), .en(en), .v(a_r), .c(a_st), .p(a_rho));
    svadd_mulq #(.VW(FR+1), .OW(CW)) u_mul_az   (.clk(clk), .en(en), .v(a_r), .c(a_ct), .p(a_z));
    svadd_mulq #(.VW(FR+1), .OW(CW)) u_mul_brho (.clk(clk), .en(en), .v(b_r), .c(b_st), .p(b_rho));
    svadd_mulq #(.VW(FR+1), .OW(CW)) u_mul_bz   (.clk(clk), .en(en), .v(b_r), .c(b_ct), .p(b_z));

    logic [4*RW-1:0]      phi_d;
    logic signed [RW-1:0] a_cp_d, a_sp_d, b_cp_d, b_sp_d;

    svadd_dly #(.W(4*RW), .DEPTH(ST_M1-ST_ROT)) u_dly_phi (
        .clk(clk), .en(en), .d({a_cp, a_sp, b_cp, b_sp}), .q(phi_d));

    assign a_cp_d = $signed(phi_d[4*RW-1:3*RW]);
    assign a_sp_d = $signed(phi_d[3*RW-1:2*RW]);
    assign b_cp_d = $signed(phi_d[2*RW-1:RW]);
    assign b_sp_d = $signed(phi_d[RW-1:0]);

    logic signed [CW-1:0] a_x, a_y, b_x, b_y;

    svadd_mulq #(.VW(CW), .OW(CW)) u_mul_ax (.clk(clk), .en(en), .v(a_rho), .c(a_cp_d), .p(a_x));
    svadd_mulq #(.VW(CW), .OW(CW)) u_mul_ay (.clk(clk), .en(en), .v(a_rho), .c(a_sp_d), .p(a_y));
    svadd_mulq #(.VW(CW), .OW(CW)) u_mul_bx (.clk(clk), .en(en), .v(b_rho), .c(b_cp_d), .p(b_x));
    svadd_mulq #(.VW(CW), .OW(CW)) u_mul_by (.clk(clk), .en(en), .v(b_rho), .c(b_sp_d), .p(b_y));

    logic [2*CW-1:0] z_d;

    svadd_dly #(.W(2*CW), .DEPTH(ST_M2-ST_M1)) u_dly_z (
        .clk(clk), .en(en), .d({a_z, b_z}), .q(z_d));

    // ---------------- vector sum ----------------
    logic signed [SW-1:0] sx_reg, sy_reg, sz_reg, sx_next, sy_next, sz_next;

    always_comb
    begin
        sx_next = SW'(a_x) + SW'(b_x);
        sy_next = SW'(a_y) + SW'(b_y);
        sz_next = SW'($signed(z_d[2*CW-1:CW])) + SW'($signed(z_d[CW-1:0]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            sz_reg <= sz_next;
        end
    end

    logic nz_xy;
    assign nz_xy = (sx_reg != '0) || (sy_reg != '0);

    // ---------------- azimuth and planar length ----------------
    logic signed [VW-1:0] v1_len, rho_raw, rho;
    logic [T-1:0]         v1_ang;

    svadd_vec u_vec_xy (.clk(clk), .en(en), .x_in(VW'(sx_reg)), .y_in(VW'(sy_reg)),
                        .len(v1_len), .ang(v1_ang));

    svadd_mulq #(.VW(VW), .OW(VW)) u_mul_g1 (.clk(clk), .en(en), .v(v1_len),
                                            .c(svadd_pkg::INV_GAIN), .p(rho_raw));

    logic                 nz_xy_g1, nz_xy_out;
    logic [SW-1:0]        sz_g1;
    logic signed [VW-1:0] sz_v;
    logic                 nz_all;

    svadd_dly #(.W(1), .DEPTH(ST_G1-ST_SUM)) u_dly_nz1 (
        .clk(clk), .en(en), .d(nz_xy), .q(nz_xy_g1));
    svadd_dly #(.W(SW), .DEPTH(ST_G1-ST_SUM)) u_dly_sz (
        .clk(clk), .en(en), .d(sz_reg), .q(sz_g1));

    assign rho    = nz_xy_g1 ? rho_raw : '0;
    assign sz_v   = VW'($signed(sz_g1));
    assign nz_all = (sz_g1 != '0) || (rho != '0);

    // ---------------- polar angle and radius ----------------
    logic signed [VW-1:0] v2_len, mag_raw;
    logic [T-1:0]         v2_ang;

    svadd_vec u_vec_zr (.clk(clk), .en(en), .x_in(sz_v), .y_in(rho),
                        .len(v2_len), .ang(v2_ang));

    svadd_mulq #(.VW(VW), .OW(VW)) u_mul_g2 (.clk(clk), .en(en), .v(v2_len),
                                            .c(svadd_pkg::INV_GAIN), .p(mag_raw));

    logic         nz_all_out;
    logic [T-1:0] pol_d, az_d;

    svadd_dly #(.W(1), .DEPTH(ST_G2-ST_G1)) u_dly_nz2 (
        .clk(clk), .en(en), .d(nz_all), .q(nz_all_out));
    svadd_dly #(.W(1), .DEPTH(ST_G2-ST_G1)) u_dly_nz1o (
        .clk(clk), .en(en), .d(nz_xy_g1), .q(nz_xy_out));
    svadd_dly #(.W(T), .DEPTH(ST_G2-ST_V2)) u_dly_pol (
        .clk(clk), .en(en), .d(v2_ang), .q(pol_d));
    svadd_dly #(.W(T), .DEPTH(ST_G2-ST_V1)) u_dly_az (
        .clk(clk), .en(en), .d(v1_ang), .q(az_d));

    // ---------------- rounding, clamp, saturation ----------------
    logic [T-1:0]            pol_t, az_t, pol_sum, az_sum;
    logic signed [VW-1:0]    mag;
    logic [VW-1:0]           mag_u;
    logic [VW:0]             rad_sum;
    logic [ANGLE_BITS-1:0]   polar_w;
    logic [RADIUS_BITS-1:0]  rad_next, rad_reg;
    logic [ANGLE_BITS-1:0]   pol_next, pol_reg, az_next, az_reg;
    logic                    ovf_next, ovf_reg;

    always_comb
    begin
        pol_t   = nz_all_out ? pol_d : '0;
        az_t    = nz_xy_out ? az_d : '0;
        mag     = nz_all_out ? mag_raw : '0;

        // negative polar turn clamps to zero
        pol_sum  = (pol_t[T-1] ? '0 : pol_t) + HALF_A;
        polar_w  = pol_sum[T-1:ASHIFT];
        pol_next = (polar_w > PI_CODE) ? PI_CODE : polar_w;

        // carry out of the turn is the wrap to zero
        az_sum  = az_t + HALF_A;
        az_next = az_sum[T-1:ASHIFT];

        mag_u    = mag[VW-1] ? '0 : $unsigned(mag);
        rad_sum  = {1'b0, mag_u} + HALF_R;
        ovf_next = |rad_sum[VW:FR];
        rad_next = ovf_next ? '1 : rad_sum[FR-1:GUARD];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg <= rad_next;
            pol_reg <= pol_next;
            az_reg  <= az_next;
            ovf_reg <= ovf_next;
        end
    end

    assign sum_radius      = rad_reg;
    assign sum_polar       = pol_reg;
    assign sum_azimuth     = az_reg;
    assign radius_overflow = ovf_reg;

    // ---------------- assertions ----------------
    `SVA_CHECK(a_ovf_sat, clk, rst_n, out_valid && radius_overflow |-> &sum_radius)
    `SVA_NEVER(a_polar_range, clk, rst_n, out_valid && (sum_polar > PI_CODE))
    `SVA_CHECK(a_ready_full, clk, rst_n, !in_ready |-> vld_reg[0] && !en)
    `SVA_CHECK(a_drain, clk, rst_n, en && vld_reg[ST_OUT-1] |=> out_valid)

endmodule

`default_nettype wire
